// File: rtl/obbsat_pkg.sv
// shared types and constants for the oriented box pair overlap test
package obbsat_pkg;

    // input field widths
    localparam int CRD_W  = 24;   // centre coordinate, Q15.8
    localparam int TRIG_W = 16;   // cos / sin, Q1.14
    localparam int HALF_W = 23;   // half extent, Q15.8

    // fraction bits of the rotation values and of the rotation matrix
    localparam int TRIG_FRAC = 14;
    localparam int ROT_FRAC  = 2 * TRIG_FRAC;

    // internal widths, all exact
    localparam int DIF_W   = CRD_W + 1;                 // centre difference
    localparam int ROT_W   = 2 * TRIG_W + 1;            // rotation matrix entry
    localparam int ABSR_W  = 2 * TRIG_W;                // |entry| + 1 lsb
    localparam int PROJ_W  = DIF_W + TRIG_W + 1;        // projected centre difference
    localparam int TMAG_W  = PROJ_W - 1;                // its magnitude
    localparam int MPROD_W = HALF_W + ABSR_W;           // half extent times |entry|
    localparam int ALHS_W  = TMAG_W + TRIG_FRAC;        // a-axis distance
    localparam int ARHS_W  = MPROD_W + 2;               // a-axis radius sum
    localparam int BRHS_W  = MPROD_W + 1;               // b-axis radius sum
    localparam int BLHS_W  = PROJ_W + ROT_W;            // b-axis distance, signed

    // split of the projection for the b-axis products
    localparam int SPLIT_W = 21;
    localparam int HI_W    = PROJ_W - SPLIT_W;
    localparam int LOP_W   = SPLIT_W + 1 + ROT_W;
    localparam int HIP_W   = HI_W + ROT_W;

    // separating axis codes
    typedef enum logic [2:0] {
        AXIS_A0   = 3'd0,
        AXIS_A1   = 3'd1,
        AXIS_B0   = 3'd2,
        AXIS_B1   = 3'd3,
        AXIS_NONE = 3'd4
    } axis_t;

    // one box pair
    typedef struct packed {
        logic signed [CRD_W-1:0]  a_centre_x;
        logic signed [CRD_W-1:0]  a_centre_y;
        logic signed [TRIG_W-1:0] a_cos;
        logic signed [TRIG_W-1:0] a_sin;
        logic [HALF_W-1:0]        a_half_x;
        logic [HALF_W-1:0]        a_half_y;
        logic signed [CRD_W-1:0]  b_centre_x;
        logic signed [CRD_W-1:0]  b_centre_y;
        logic signed [TRIG_W-1:0] b_cos;
        logic signed [TRIG_W-1:0] b_sin;
        logic [HALF_W-1:0]        b_half_x;
        logic [HALF_W-1:0]        b_half_y;
    } in_t;

    // one test result
    typedef struct packed {
        logic       overlap;
        logic [2:0] separating_axis;
    } out_t;

endpackage

// File: rtl/obbsat_split_mul.sv
// projection times rotation entry, split into two registered partial products
module obbsat_split_mul
    import obbsat_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [PROJ_W-1:0] a,
    input  logic signed [ROT_W-1:0]  b,
    output logic signed [LOP_W-1:0]  lo_prod,
    output logic signed [HIP_W-1:0]  hi_prod
);

    logic signed [SPLIT_W:0]   a_lo;
    logic signed [HI_W-1:0]    a_hi;
    logic signed [LOP_W-1:0]   lo_next;
    logic signed [HIP_W-1:0]   hi_next;
    logic signed [LOP_W-1:0]   lo_reg;
    logic signed [HIP_W-1:0]   hi_reg;

    // low part as a positive value, high part keeps the sign
    assign a_lo    = $signed({1'b0, a[SPLIT_W-1:0]});
    assign a_hi    = a[PROJ_W-1:SPLIT_W];
    assign lo_next = a_lo * b;
    assign hi_next = a_hi * b;

    // partial product registers
    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign lo_prod = lo_reg;
    assign hi_prod = hi_reg;

endmodule

// File: rtl/obb_pair_overlap_2d_core.sv
// separating-axis overlap test for two 2d oriented boxes, pipelined
//
// s_ channel: one box pair per transfer (centres, cos/sin, half extents).
// m_ channel: one result per pair, the overlap flag and the first
// separating axis (a first, a second, b first, b second, or none).
// Results leave in the order the pairs arrived.
//
// An input transfer reaches m_valid through these registered stages: the
// rotation matrix and centre difference, projection onto box a, the
// radius and distance multipliers, the sums, then the compares into
// the output register. A pair per clock goes in while m_ready is high.
//
// Each stage carries its own valid bit. When the receiver stalls, the
// output register holds and the stages in front fill their empty slots
// before s_ready drops, so no transfer is lost or repeated.
// A synchronous reset (aresetn low) empties every stage; nothing else
// is kept between pairs.
module obb_pair_overlap_2d_core
    import obbsat_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    typedef struct packed {
        logic [HALF_W-1:0] ea0;
        logic [HALF_W-1:0] ea1;
        logic [HALF_W-1:0] eb0;
        logic [HALF_W-1:0] eb1;
    } halves_t;

    // stage valids and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic en1, en2, en3, en4, en5;

    assign en5     = !m_valid_reg || m_ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg      <= s_valid;
            if (en2) v2_reg      <= v1_reg;
            if (en3) v3_reg      <= v2_reg;
            if (en4) v4_reg      <= v3_reg;
            if (en5) m_valid_reg <= v4_reg;
        end
    end

    // stage 1: rotation matrix between the boxes and centre difference
    logic signed [CRD_W-1:0]  ax, ay, bx, by;
    logic signed [TRIG_W-1:0] ca, sa, cb, sb;
    logic signed [ROT_W-1:0]  r00_next, r01_next, r00_1_reg, r01_1_reg;
    logic signed [DIF_W-1:0]  dx_next, dy_next, dx_reg, dy_reg;
    logic signed [TRIG_W-1:0] ca_reg, sa_reg;
    halves_t                  h1_reg;

    assign ax = s_data.a_centre_x;
    assign ay = s_data.a_centre_y;
    assign bx = s_data.b_centre_x;
    assign by = s_data.b_centre_y;
    assign ca = s_data.a_cos;
    assign sa = s_data.a_sin;
    assign cb = s_data.b_cos;
    assign sb = s_data.b_sin;

    // r11 equals r00 and r10 is the negative of r01
    assign r00_next = ca * cb + sa * sb;
    assign r01_next = sa * cb - ca * sb;
    assign dx_next  = bx - ax;
    assign dy_next  = by - ay;

    always_ff @(posedge aclk) begin
        if (en1) begin
            r00_1_reg  <= r00_next;
            r01_1_reg  <= r01_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            ca_reg     <= ca;
            sa_reg     <= sa;
            h1_reg.ea0 <= s_data.a_half_x;
            h1_reg.ea1 <= s_data.a_half_y;
            h1_reg.eb0 <= s_data.b_half_x;
            h1_reg.eb1 <= s_data.b_half_y;
        end
    end

    // stage 2: project the centre difference onto box a, |r| plus one lsb
    logic signed [PROJ_W-1:0] t0_next, t1_next, t0_reg, t1_reg;
    logic signed [ROT_W-1:0]  rmag0, rmag1, r00_2_reg, r01_2_reg;
    logic [ABSR_W-1:0]        absr0_next, absr1_next, absr0_reg, absr1_reg;
    halves_t                  h2_reg;

    assign t0_next    = dx_reg * ca_reg + dy_reg * sa_reg;
    assign t1_next    = dy_reg * ca_reg - dx_reg * sa_reg;
    assign rmag0      = r00_1_reg[ROT_W-1] ? -r00_1_reg : r00_1_reg;
    assign rmag1      = r01_1_reg[ROT_W-1] ? -r01_1_reg : r01_1_reg;
    assign absr0_next = ABSR_W'(rmag0 + ROT_W'(1));
    assign absr1_next = ABSR_W'(rmag1 + ROT_W'(1));

    always_ff @(posedge aclk) begin
        if (en2) begin
            t0_reg    <= t0_next;
            t1_reg    <= t1_next;
            r00_2_reg <= r00_1_reg;
            r01_2_reg <= r01_1_reg;
            absr0_reg <= absr0_next;
            absr1_reg <= absr1_next;
            h2_reg    <= h1_reg;
        end
    end

    // stage 3: radius products and split distance products
    logic signed [PROJ_W-1:0] tabs0, tabs1;
    logic [TMAG_W-1:0]        tmag0_reg, tmag1_reg;
    logic [MPROD_W-1:0]       ma00_reg, ma01_reg, ma10_reg, ma11_reg;
    logic [MPROD_W-1:0]       mb00_reg, mb01_reg, mb10_reg, mb11_reg;
    halves_t                  h3_reg;
    logic signed [LOP_W-1:0]  lo_t0r00, lo_t1r01, lo_t0r01, lo_t1r00;
    logic signed [HIP_W-1:0]  hi_t0r00, hi_t1r01, hi_t0r01, hi_t1r00;

    assign tabs0 = t0_reg[PROJ_W-1] ? -t0_reg : t0_reg;
    assign tabs1 = t1_reg[PROJ_W-1] ? -t1_reg : t1_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            tmag0_reg <= tabs0[TMAG_W-1:0];
            tmag1_reg <= tabs1[TMAG_W-1:0];
            ma00_reg  <= h2_reg.eb0 * absr0_reg;
            ma01_reg  <= h2_reg.eb1 * absr1_reg;
            ma10_reg  <= h2_reg.eb0 * absr1_reg;
            ma11_reg  <= h2_reg.eb1 * absr0_reg;
            mb00_reg  <= h2_reg.ea0 * absr0_reg;
            mb01_reg  <= h2_reg.ea1 * absr1_reg;
            mb10_reg  <= h2_reg.ea0 * absr1_reg;
            mb11_reg  <= h2_reg.ea1 * absr0_reg;
            h3_reg    <= h2_reg;
        end
    end

    obbsat_split_mul u_t0r00 (
        .aclk(aclk), .en(en3), .a(t0_reg), .b(r00_2_reg),
        .lo_prod(lo_t0r00), .hi_prod(hi_t0r00)
    );

    obbsat_split_mul u_t1r01 (
        .aclk(aclk), .en(en3), .a(t1_reg), .b(r01_2_reg),
        .lo_prod(lo_t1r01), .hi_prod(hi_t1r01)
    );

    obbsat_split_mul u_t0r01 (
        .aclk(aclk), .en(en3), .a(t0_reg), .b(r01_2_reg),
        .lo_prod(lo_t0r01), .hi_prod(hi_t0r01)
    );

    obbsat_split_mul u_t1r00 (
        .aclk(aclk), .en(en3), .a(t1_reg), .b(r00_2_reg),
        .lo_prod(lo_t1r00), .hi_prod(hi_t1r00)
    );

    // stage 4: distance and radius sums for all four axes
    logic [ALHS_W-1:0]        alhs0_reg, alhs1_reg;
    logic [ARHS_W-1:0]        arhs0_next, arhs1_next, arhs0_reg, arhs1_reg;
    logic [BRHS_W-1:0]        brhs0_next, brhs1_next, brhs0_reg, brhs1_reg;
    logic signed [BLHS_W-1:0] p_t0r00, p_t1r01, p_t0r01, p_t1r00;
    logic signed [BLHS_W-1:0] blhs0_next, blhs1_next, blhs0_reg, blhs1_reg;

    assign arhs0_next = (ARHS_W'(h3_reg.ea0) << ROT_FRAC)
                      + ARHS_W'(ma00_reg) + ARHS_W'(ma01_reg);
    assign arhs1_next = (ARHS_W'(h3_reg.ea1) << ROT_FRAC)
                      + ARHS_W'(ma10_reg) + ARHS_W'(ma11_reg);
    assign brhs0_next = (BRHS_W'(h3_reg.eb0) << ROT_FRAC)
                      + BRHS_W'(mb00_reg) + BRHS_W'(mb01_reg);
    assign brhs1_next = (BRHS_W'(h3_reg.eb1) << ROT_FRAC)
                      + BRHS_W'(mb10_reg) + BRHS_W'(mb11_reg);

    // rebuild the full products from their halves
    assign p_t0r00 = (BLHS_W'(hi_t0r00) <<< SPLIT_W) + BLHS_W'(lo_t0r00);
    assign p_t1r01 = (BLHS_W'(hi_t1r01) <<< SPLIT_W) + BLHS_W'(lo_t1r01);
    assign p_t0r01 = (BLHS_W'(hi_t0r01) <<< SPLIT_W) + BLHS_W'(lo_t0r01);
    assign p_t1r00 = (BLHS_W'(hi_t1r00) <<< SPLIT_W) + BLHS_W'(lo_t1r00);

    // b first axis: t0*r00 + t1*r10, b second axis: t0*r01 + t1*r11
    assign blhs0_next = p_t0r00 - p_t1r01;
    assign blhs1_next = p_t0r01 + p_t1r00;

    always_ff @(posedge aclk) begin
        if (en4) begin
            alhs0_reg <= {tmag0_reg, {TRIG_FRAC{1'b0}}};
            alhs1_reg <= {tmag1_reg, {TRIG_FRAC{1'b0}}};
            arhs0_reg <= arhs0_next;
            arhs1_reg <= arhs1_next;
            brhs0_reg <= brhs0_next;
            brhs1_reg <= brhs1_next;
            blhs0_reg <= blhs0_next;
            blhs1_reg <= blhs1_next;
        end
    end

    // stage 5: compares and first separating axis
    logic [BLHS_W-1:0] babs0, babs1, bcmp0, bcmp1;
    logic              sep_a0, sep_a1, sep_b0, sep_b1;
    out_t              out_next, out_reg;

    assign babs0  = blhs0_reg[BLHS_W-1] ? BLHS_W'(-blhs0_reg) : BLHS_W'(blhs0_reg);
    assign babs1  = blhs1_reg[BLHS_W-1] ? BLHS_W'(-blhs1_reg) : BLHS_W'(blhs1_reg);
    assign bcmp0  = BLHS_W'({brhs0_reg, {TRIG_FRAC{1'b0}}});
    assign bcmp1  = BLHS_W'({brhs1_reg, {TRIG_FRAC{1'b0}}});
    assign sep_a0 = ARHS_W'(alhs0_reg) > arhs0_reg;
    assign sep_a1 = ARHS_W'(alhs1_reg) > arhs1_reg;
    assign sep_b0 = babs0 > bcmp0;
    assign sep_b1 = babs1 > bcmp1;

    always_comb begin
        out_next.overlap = 1'b0;
        if (sep_a0) begin
            out_next.separating_axis = AXIS_A0;
        end else if (sep_a1) begin
            out_next.separating_axis = AXIS_A1;
        end else if (sep_b0) begin
            out_next.separating_axis = AXIS_B0;
        end else if (sep_b1) begin
            out_next.separating_axis = AXIS_B1;
        end else begin
            out_next.separating_axis = AXIS_NONE;
            out_next.overlap         = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

// File: rtl/obbsat_checker.sv
// port-level checks for the oriented box overlap core, bound to the top level
module obbsat_checker
    import obbsat_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // a stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // overlap flag and axis code agree
    a_flag_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.overlap == (m_data.separating_axis == AXIS_NONE)))
        else $error("overlap flag disagrees with axis code");

    // axis code stays within its range
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.separating_axis <= AXIS_NONE))
        else $error("axis code out of range");

    // a draining or empty output never blocks the input
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled while output can move");

endmodule

bind obb_pair_overlap_2d_core obbsat_checker u_obbsat_checker (.*);
